[rtl/bfl_pkg.sv]
// ----------------------------------------------------------------------------
// bfl_pkg
// Types, constants and codes shared by the bucket free list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bfl_pkg;

  localparam int HEAP_GRANULES = 4096;
  localparam int NUM_BUCKETS   = 6;
  localparam int HEADER_BYTES  = 16;
  localparam int ALIGN_BYTES   = 16;

  localparam int MAX_BUCKETS = 6;
  localparam int BKT_W       = 3;
  localparam int GRAN_W      = $clog2(HEAP_GRANULES);
  localparam int LINK_W      = GRAN_W + 1;
  localparam int ALIGN_SHIFT = $clog2(ALIGN_BYTES);
  localparam int REG_W       = 17;
  localparam int CFG_IDX_W   = 3;
  localparam int SIZE_W      = 32;
  localparam int OFF_W       = 16;
  localparam int BLK_W       = SIZE_W + 1;
  localparam int END_W       = SIZE_W + 2;

  localparam logic [REG_W-1:0] SPACE_LIMIT = REG_W'(65536);

  localparam logic [REG_W-1:0] BKT_RESET [MAX_BUCKETS] = '{
    REG_W'(64), REG_W'(256), REG_W'(1024), REG_W'(4096), REG_W'(16384), REG_W'(0)
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAP    = 3'd0,
    REG_RESERVE = 3'd1,
    REG_BKT0    = 3'd2,
    REG_BKT1    = 3'd3,
    REG_BKT2    = 3'd4,
    REG_BKT3    = 3'd5,
    REG_BKT4    = 3'd6,
    REG_BKT5    = 3'd7
  } cfg_reg_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_NEW     = 3'd0,
    ST_REUSED  = 3'd1,
    ST_FAIL    = 3'd2,
    ST_FREED   = 3'd3,
    ST_IGNORED = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic                sz_we;
    logic                lk_we;
    logic [GRAN_W-1:0]   addr;
    logic [SIZE_W-1:0]   sz;
    logic [LINK_W-1:0]   lk;
  } store_wr_t;

  typedef struct packed {
    logic [SIZE_W-1:0]   sz;
    logic [LINK_W-1:0]   lk;
  } store_rd_t;

endpackage

`default_nettype wire

[rtl/bfl_if.sv]
// ----------------------------------------------------------------------------
// bfl_req_if / bfl_rsp_if
// Valid/ready channels for allocator requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfl_req_if;
  import bfl_pkg::*;
  logic                valid;
  logic                ready;
  logic                op;
  logic [SIZE_W-1:0]   request_size;
  logic [OFF_W-1:0]    block_offset;

  modport source (output valid, output op, output request_size, output block_offset,
                  input ready);
  modport sink   (input valid, input op, input request_size, input block_offset,
                  output ready);
endinterface

interface bfl_rsp_if;
  import bfl_pkg::*;
  logic                valid;
  logic                ready;
  logic [OFF_W-1:0]    data_offset;
  logic [2:0]          status;

  modport source (output valid, output data_offset, output status, input ready);
  modport sink   (input valid, input data_offset, input status, output ready);
endinterface

`default_nettype wire

[rtl/bucket_free_list_allocator_core.sv]
// ----------------------------------------------------------------------------
// bucket_free_list_allocator_core
// Segregated free list heap allocator with a bump pointer.
// ----------------------------------------------------------------------------
// Flow: memory read at the request beat, then read-modify-write in S_EXEC and a
//   registered result; S_EXEC is extended only while the result register is stalled.
// Requests: a new one is taken only in S_IDLE, after the size/link memory
//   read and its write-back for the previous one.
// Reset: clears list heads, bump pointer, heap/reserve and result valid;
//   bucket sizes go to defaults. Size and link memories are not cleared.
`default_nettype none

module bucket_free_list_allocator_core
  import bfl_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  bfl_req_if.sink                   req_i,
  bfl_rsp_if.source                 rsp_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [REG_W-1:0]     cfg_wdata_i
);

  state_e              state_q, state_d;
  logic [REG_W-1:0]    heap_q, reserve_q;
  logic [REG_W-1:0]    bkt_q [MAX_BUCKETS];
  logic [REG_W-1:0]    bump_q, bump_d;
  logic [LINK_W-1:0]   heads_q [MAX_BUCKETS];
  logic [LINK_W-1:0]   heads_d [MAX_BUCKETS];

  // request latched at the beat
  op_e                 op_q;
  logic [SIZE_W-1:0]   size_q;
  logic [BLK_W-1:0]    blk_q;
  logic                hit_q, head_nz_q, free_ok_q;
  logic [BKT_W-1:0]    bidx_q;
  logic [GRAN_W-1:0]   g_q;
  logic [OFF_W-1:0]    off_q;

  logic                rsp_vld_q, rsp_vld_d;
  logic [OFF_W-1:0]    rsp_data_q, rsp_data_d;
  status_e             rsp_st_q, rsp_st_d;

  logic                accept, go;
  logic                srch_hit;
  logic [BKT_W-1:0]    srch_idx, push_idx, head_rd_idx;
  logic                push_hit;
  logic [LINK_W-1:0]   head_rd;
  logic [SIZE_W-1:0]   eff_size;
  logic [BLK_W-1:0]    blk;
  logic [OFF_W-1:0]    free_hdr;
  logic                free_ok;
  logic [GRAN_W-1:0]   free_g, pop_g, rd_addr;

  logic [REG_W-1:0]    heap_lim, lim_net;
  logic                res_over;
  logic [END_W-1:0]    bump_end;

  store_rd_t           st_rd;
  store_wr_t           st_wr;

  assign accept      = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign go          = (state_q == S_EXEC) && (!rsp_vld_q || rsp_o.ready);

  // bucket search for the incoming size
  always_comb begin
    logic done;
    srch_hit = 1'b0;
    srch_idx = '0;
    done     = 1'b0;
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      if (!done) begin
        if (bkt_q[i] == '0) begin
          done = 1'b1;
        end else if (req_i.request_size <= SIZE_W'(bkt_q[i])) begin
          srch_hit = 1'b1;
          srch_idx = BKT_W'(i);
          done     = 1'b1;
        end
      end
    end
  end

  // exact size match of the stored block being freed
  always_comb begin
    logic done;
    push_hit = 1'b0;
    push_idx = '0;
    done     = 1'b0;
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      if (!done) begin
        if (bkt_q[i] == '0) begin
          done = 1'b1;
        end else if (st_rd.sz == SIZE_W'(bkt_q[i])) begin
          push_hit = 1'b1;
          push_idx = BKT_W'(i);
          done     = 1'b1;
        end
      end
    end
  end

  assign head_rd_idx = (state_q == S_EXEC) ? push_idx : srch_idx;
  assign head_rd     = heads_q[head_rd_idx];

  assign eff_size = srch_hit ? SIZE_W'(bkt_q[srch_idx]) : req_i.request_size;
  assign blk      = (BLK_W'(eff_size) + BLK_W'(HEADER_BYTES + ALIGN_BYTES - 1))
                    & ~BLK_W'(ALIGN_BYTES - 1);

  assign free_hdr = req_i.block_offset - OFF_W'(HEADER_BYTES);
  assign free_ok  = (req_i.block_offset >= OFF_W'(HEADER_BYTES))
                 && (free_hdr[ALIGN_SHIFT-1:0] == '0)
                 && ((32'(free_hdr) >> ALIGN_SHIFT) < HEAP_GRANULES);
  assign free_g   = free_hdr[ALIGN_SHIFT +: GRAN_W];
  assign pop_g    = GRAN_W'(head_rd - LINK_W'(1));
  assign rd_addr  = (req_i.op == OP_FREE) ? free_g : pop_g;

  bfl_store u_store (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (rd_addr),
    .rd_o      (st_rd),
    .wr_i      (st_wr)
  );

  assign heap_lim = (heap_q > SPACE_LIMIT) ? SPACE_LIMIT : heap_q;
  assign res_over = reserve_q > heap_lim;
  assign lim_net  = heap_lim - reserve_q;
  assign bump_end = END_W'(bump_q) + END_W'(blk_q);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= op_e'(req_i.op);
      size_q    <= eff_size;
      blk_q     <= blk;
      hit_q     <= srch_hit;
      bidx_q    <= srch_idx;
      head_nz_q <= (head_rd != '0);
      free_ok_q <= free_ok;
      g_q       <= rd_addr;
      off_q     <= req_i.block_offset;
    end
  end

  always_comb begin
    state_d    = state_q;
    bump_d     = bump_q;
    heads_d    = heads_q;
    rsp_vld_d  = rsp_vld_q && !rsp_o.ready;
    rsp_data_d = rsp_data_q;
    rsp_st_d   = rsp_st_q;
    st_wr      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (go) begin
          state_d    = S_IDLE;
          rsp_vld_d  = 1'b1;
          rsp_data_d = '0;
          if (op_q == OP_ALLOC) begin
            rsp_st_d = ST_FAIL;
            if (heap_q == '0) begin
              rsp_st_d = ST_FAIL;
            end else if (hit_q && head_nz_q) begin
              heads_d[bidx_q] = st_rd.lk;
              st_wr.lk_we     = 1'b1;
              st_wr.addr      = g_q;
              st_wr.lk        = '0;
              rsp_data_d      = OFF_W'(32'(g_q) * ALIGN_BYTES + HEADER_BYTES);
              rsp_st_d        = ST_REUSED;
            end else if (!res_over && (bump_end <= END_W'(lim_net))
                         && (bump_q <= REG_W'(65535 - HEADER_BYTES))) begin
              bump_d      = bump_end[REG_W-1:0];
              st_wr.sz_we = 1'b1;
              st_wr.lk_we = 1'b1;
              st_wr.addr  = bump_q[ALIGN_SHIFT +: GRAN_W];
              st_wr.sz    = size_q;
              st_wr.lk    = '0;
              rsp_data_d  = bump_q[OFF_W-1:0] + OFF_W'(HEADER_BYTES);
              rsp_st_d    = ST_NEW;
            end
          end else begin
            rsp_st_d = ST_IGNORED;
            if (free_ok_q && push_hit) begin
              st_wr.lk_we       = 1'b1;
              st_wr.addr        = g_q;
              st_wr.lk          = head_rd;
              heads_d[push_idx] = LINK_W'(g_q) + LINK_W'(1);
              rsp_data_d        = off_q;
              rsp_st_d          = ST_FREED;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
    // heap size write restarts the bump pointer
    if (cfg_we_i && (cfg_idx_i == REG_HEAP)) begin
      bump_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rsp_vld_q <= 1'b0;
      bump_q    <= '0;
      heap_q    <= '0;
      reserve_q <= '0;
      for (int i = 0; i < MAX_BUCKETS; i++) begin
        bkt_q[i]   <= BKT_RESET[i];
        heads_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      rsp_vld_q <= rsp_vld_d;
      bump_q    <= bump_d;
      heads_q   <= heads_d;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i)) inside
          REG_HEAP: begin
            heap_q <= cfg_wdata_i;
          end
          REG_RESERVE: reserve_q <= cfg_wdata_i;
          REG_BKT0, REG_BKT1, REG_BKT2, REG_BKT3, REG_BKT4, REG_BKT5: begin
            bkt_q[BKT_W'(cfg_idx_i - REG_BKT0)] <= cfg_wdata_i;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_data_q <= rsp_data_d;
    rsp_st_q   <= rsp_st_d;
  end

  assign rsp_o.valid       = rsp_vld_q;
  assign rsp_o.data_offset = rsp_data_q;
  assign rsp_o.status      = rsp_st_q;

endmodule

`default_nettype wire

[rtl/bfl_store.sv]
// ----------------------------------------------------------------------------
// bfl_store
// Per-granule block size and list link memories, one read and one write
// port each, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfl_store
  import bfl_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rd_en_i,
  input  wire logic [GRAN_W-1:0] rd_addr_i,
  output store_rd_t              rd_o,
  input  wire store_wr_t         wr_i
);

  logic [SIZE_W-1:0] size_mem [HEAP_GRANULES];
  logic [LINK_W-1:0] link_mem [HEAP_GRANULES];
  logic [SIZE_W-1:0] sz_rd_q;
  logic [LINK_W-1:0] lk_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.sz_we) begin
      size_mem[wr_i.addr] <= wr_i.sz;
    end
    if (rd_en_i) begin
      sz_rd_q <= size_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.lk_we) begin
      link_mem[wr_i.addr] <= wr_i.lk;
    end
    if (rd_en_i) begin
      lk_rd_q <= link_mem[rd_addr_i];
    end
  end

  assign rd_o.sz = sz_rd_q;
  assign rd_o.lk = lk_rd_q;

endmodule

`default_nettype wire

[rtl/bfl_checker.sv]
// ----------------------------------------------------------------------------
// bfl_checker
// Port-level assertions for the allocator core, bound to the allocator core.
// ----------------------------------------------------------------------------
`default_nettype none

module bfl_checker
  import bfl_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              req_valid_i,
  input wire logic              req_ready_i,
  input wire logic              rsp_valid_i,
  input wire logic              rsp_ready_i,
  input wire logic [OFF_W-1:0]  rsp_data_i,
  input wire logic [2:0]        rsp_status_i
);

  // one request in flight: no beat in the cycle after a beat
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while previous one in progress");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(rsp_data_i) && $stable(rsp_status_i))
    else $error("stalled result changed");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == ST_FAIL || rsp_status_i == ST_IGNORED)
      |-> rsp_data_i == '0)
    else $error("failed result carries an offset");

  a_ok_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == ST_NEW || rsp_status_i == ST_REUSED
                    || rsp_status_i == ST_FREED)
      |-> rsp_data_i[ALIGN_SHIFT-1:0] == '0 && rsp_data_i >= OFF_W'(HEADER_BYTES))
    else $error("result offset not a block data offset");

endmodule

bind bucket_free_list_allocator_core bfl_checker u_bfl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_data_i   (rsp_o.data_offset),
  .rsp_status_i (rsp_o.status)
);

`default_nettype wire
